// ===== rtl/core/geodesic_triangle_subdivide_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the geodesic subdivider
// Each macro becomes a labeled concurrent assertion, or nothing when
// assertions are compiled out.
// ---------------------------------------------------------------------------
`ifndef GEODESIC_TRIANGLE_SUBDIVIDE_DEFINES_SVH
`define GEODESIC_TRIANGLE_SUBDIVIDE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gts_pkg.sv =====
// ---------------------------------------------------------------------------
// gts_pkg
// Shared payload types for the geodesic subdivider channels.
// ---------------------------------------------------------------------------
package gts_pkg;

    localparam int IDX_W   = 24;
    localparam int COORD_W = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner0_x;
        logic signed [COORD_W-1:0] corner0_y;
        logic signed [COORD_W-1:0] corner0_z;
        logic signed [COORD_W-1:0] corner1_x;
        logic signed [COORD_W-1:0] corner1_y;
        logic signed [COORD_W-1:0] corner1_z;
        logic signed [COORD_W-1:0] corner2_x;
        logic signed [COORD_W-1:0] corner2_y;
        logic signed [COORD_W-1:0] corner2_z;
        logic [IDX_W-1:0]          corner0_index;
        logic [IDX_W-1:0]          corner1_index;
        logic [IDX_W-1:0]          corner2_index;
    } tri_t;

    typedef struct packed {
        logic                      result_kind;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [IDX_W-1:0]          face_a;
        logic [IDX_W-1:0]          face_b;
        logic [IDX_W-1:0]          face_c;
        logic                      index_overflow;
        logic                      last;
    } res_t;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FACE   = 1'b1;

endpackage

// ===== rtl/core/gts_if.sv =====
// ---------------------------------------------------------------------------
// gts_tri_if / gts_res_if
// Valid/ready channels carrying triangles in and results out.
// ---------------------------------------------------------------------------
interface gts_tri_if;
    logic          valid;
    logic          ready;
    gts_pkg::tri_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gts_res_if;
    logic          valid;
    logic          ready;
    gts_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/geodesic_triangle_subdivide.sv =====
// ---------------------------------------------------------------------------
// geodesic_triangle_subdivide
// One 1-to-4 geodesic subdivision step per triangle.
// ---------------------------------------------------------------------------
// A triangle is taken when the block is idle; it then stays busy until its
// seven results (three vertices k01, k02, k12, then four faces) have all been
// handed to the output register. Per edge the work runs on one shared
// sequencer: add and normalize, the sum of squares through one 32x32
// multiplier, a bit-pair square root, and per axis one multiply, a 62-step
// restoring divider and a store step. The vertex is then emitted; a zero
// midpoint skips straight to it, at the origin. Each vertex result is
// emitted as soon as its edge is done, and the edge engine waits while a
// result sits unaccepted.
`include "geodesic_triangle_subdivide_defines.svh"

module geodesic_triangle_subdivide #(
    parameter int VERTEX_INDEX_BITS = 24,
    parameter int COORD_FRAC_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    gts_tri_if.sink     tri_in,
    gts_res_if.source   res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = VERTEX_INDEX_BITS;
    localparam int IW = gts_pkg::IDX_W;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_NORM  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_VOUT  = 4'd7;
    localparam logic [3:0] S_FOUT  = 4'd8;

    localparam logic [0:0] REG_RADIUS = 1'd0;
    localparam logic [0:0] REG_BASE   = 1'd1;

    logic [30:0]   radius_reg;
    logic [23:0]   base_reg;
    logic [VW-1:0] nvi_reg;
    logic          ovf_reg;

    logic [3:0]    state_reg;
    gts_pkg::tri_t tri_reg;
    logic [1:0]    edge_reg;   // 0:01 1:02 2:12
    logic [1:0]    axis_reg;
    logic [1:0]    face_reg;
    logic [6:0]    cnt_reg;
    logic [VW-1:0] k_reg [3];

    logic [32:0]   mag_reg [3];
    logic [2:0]    neg_reg;
    logic          zero_reg;
    logic [63:0]   sq_reg;
    logic [63:0]   rem_reg;
    logic [31:0]   root_reg;
    logic [61:0]   num_reg;
    logic [31:0]   quo_reg;
    logic [31:0]   pos_reg [3];

    logic          out_valid_reg;
    gts_pkg::res_t out_reg;

    // ---------------- configuration port ----------------
    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[2])
            REG_RADIUS: prdata = {1'b0, radius_reg};
            REG_BASE:   prdata = {8'd0, base_reg};
            default:    prdata = '0;
        endcase
        if (paddr[1:0] != 2'd0)
            prdata = '0;
    end

    // ---------------- edge operands ----------------
    logic signed [31:0] ca [3];
    logic signed [31:0] cb [3];
    always_comb
    begin
        case (edge_reg)
            2'd0:
            begin
                ca = '{tri_reg.corner0_x, tri_reg.corner0_y, tri_reg.corner0_z};
                cb = '{tri_reg.corner1_x, tri_reg.corner1_y, tri_reg.corner1_z};
            end
            2'd1:
            begin
                ca = '{tri_reg.corner0_x, tri_reg.corner0_y, tri_reg.corner0_z};
                cb = '{tri_reg.corner2_x, tri_reg.corner2_y, tri_reg.corner2_z};
            end
            default:
            begin
                ca = '{tri_reg.corner1_x, tri_reg.corner1_y, tri_reg.corner1_z};
                cb = '{tri_reg.corner2_x, tri_reg.corner2_y, tri_reg.corner2_z};
            end
        endcase
    end

    // max magnitude and normalize shift
    logic [32:0] mx;
    logic [5:0]  lz;
    logic        found;
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
        lz = 6'd0;
        found = 1'b0;
        for (int i = 32; i >= 0; i--)
        begin
            if (!found && mx[i])
            begin
                found = 1'b1;
                lz = 6'(i);
            end
        end
    end

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            mul_a = mag_reg[axis_reg][31:0];
            mul_b = mag_reg[axis_reg][31:0];
        end
        else
        begin
            mul_a = {1'b0, radius_reg};
            mul_b = mag_reg[axis_reg][31:0];
        end
        mul_p = mul_a * mul_b;
    end

    // sqrt step (bit pair)
    logic [65:0] sq_trial;
    logic [63:0] rem_sh;
    always_comb
    begin
        rem_sh   = {rem_reg[61:0], sq_reg[63:62]};
        sq_trial = {2'b00, rem_sh} - {32'd0, root_reg, 2'b01};
    end

    // divide step: num_reg holds dividend, rem_reg partial remainder
    logic [64:0] dv_sh;
    logic [64:0] dv_diff;
    always_comb
    begin
        dv_sh   = {rem_reg, num_reg[61]};
        dv_diff = dv_sh - {33'd0, root_reg};
    end

    wire in_acc  = tri_in.valid && tri_in.ready;
    wire out_acc = res_out.valid && res_out.ready;
    assign tri_in.ready  = (state_reg == S_IDLE);
    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_reg;

    // k value with wrap
    logic [VW-1:0] k1, k2;
    assign k1 = nvi_reg + VW'(1);
    assign k2 = nvi_reg + VW'(2);

    // ---------------- control and datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        gts_pkg::res_t out_next;
        logic          out_load;
        if (!rst_n)
        begin
            radius_reg    <= 31'd65536;
            base_reg      <= '0;
            nvi_reg       <= '0;
            ovf_reg       <= 1'b0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            edge_reg      <= '0;
            axis_reg      <= '0;
            face_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_next = out_reg;
            out_load = 1'b0;
            if (cfg_wr && paddr[1:0] == 2'd0)
            begin
                unique case (paddr[2])
                    REG_RADIUS: radius_reg <= pwdata[30:0];
                    REG_BASE:
                    begin
                        base_reg <= pwdata[23:0];
                        nvi_reg  <= VW'(pwdata[23:0]);
                        ovf_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        tri_reg  <= tri_in.data;
                        k_reg[0] <= nvi_reg;
                        k_reg[1] <= k1;
                        k_reg[2] <= k2;
                        nvi_reg  <= nvi_reg + VW'(3);
                        if (k1 == '0 || k2 == '0 || (k2 + VW'(1)) == '0)
                            ovf_reg <= 1'b1;
                        edge_reg  <= 2'd0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        logic signed [32:0] s;
                        s = 33'(ca[j]) + 33'(cb[j]);
                        neg_reg[j] <= s[32];
                        mag_reg[j] <= s[32] ? 33'(-s) : s;
                    end
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    zero_reg <= !found;
                    for (int j = 0; j < 3; j++)
                    begin
                        if (lz >= 6'd30)
                            mag_reg[j] <= mag_reg[j] >> (lz - 6'd30);
                        else
                            mag_reg[j] <= mag_reg[j] << (6'd30 - lz);
                    end
                    sq_reg    <= '0;
                    axis_reg  <= '0;
                    state_reg <= found ? S_SQ : S_VOUT;
                    for (int j = 0; j < 3; j++)
                        pos_reg[j] <= '0;
                end
                S_SQ:
                begin
                    sq_reg <= sq_reg + mul_p;
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                S_SQRT:
                begin
                    sq_reg <= {sq_reg[61:0], 2'b00};
                    if (!sq_trial[65])
                    begin
                        rem_reg  <= sq_trial[63:0];
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd31)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    num_reg   <= 62'(mul_p) + 62'(root_reg >> 1);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[60:0], 1'b0};
                    if (!dv_diff[64])
                    begin
                        rem_reg <= dv_diff[63:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= dv_sh[63:0];
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd61)
                        state_reg <= S_VOUT;
                end
                S_VOUT:
                begin
                    if (!zero_reg && cnt_reg == 7'd62)
                    begin
                        pos_reg[axis_reg] <= neg_reg[axis_reg] ? -quo_reg : quo_reg;
                        cnt_reg <= '0;
                        if (axis_reg != 2'd2)
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_MUL;
                        end
                    end
                    else if (!out_valid_reg || out_acc)
                    begin
                        out_load                = 1'b1;
                        out_next                = '0;
                        out_next.result_kind    = gts_pkg::KIND_VERTEX;
                        out_next.vertex_index   = IW'(k_reg[edge_reg]);
                        out_next.pos_x          = pos_reg[0];
                        out_next.pos_y          = pos_reg[1];
                        out_next.pos_z          = pos_reg[2];
                        out_next.index_overflow = ovf_reg;
                        axis_reg             <= '0;
                        face_reg             <= '0;
                        if (edge_reg == 2'd2)
                            state_reg <= S_FOUT;
                        else
                        begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_FOUT:
                begin
                    if (!out_valid_reg || out_acc)
                    begin
                        out_load                = 1'b1;
                        out_next                = '0;
                        out_next.result_kind    = gts_pkg::KIND_FACE;
                        out_next.index_overflow = ovf_reg;
                        case (face_reg)
                            2'd0:
                            begin
                                out_next.face_a = IW'(VW'(tri_reg.corner0_index));
                                out_next.face_b = IW'(k_reg[0]);
                                out_next.face_c = IW'(k_reg[1]);
                            end
                            2'd1:
                            begin
                                out_next.face_a = IW'(VW'(tri_reg.corner1_index));
                                out_next.face_b = IW'(k_reg[0]);
                                out_next.face_c = IW'(k_reg[2]);
                            end
                            2'd2:
                            begin
                                out_next.face_a = IW'(VW'(tri_reg.corner2_index));
                                out_next.face_b = IW'(k_reg[1]);
                                out_next.face_c = IW'(k_reg[2]);
                            end
                            default:
                            begin
                                out_next.face_a = IW'(k_reg[0]);
                                out_next.face_b = IW'(k_reg[1]);
                                out_next.face_c = IW'(k_reg[2]);
                                out_next.last   = 1'b1;
                            end
                        endcase
                        face_reg <= face_reg + 2'd1;
                        if (face_reg == 2'd3)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // output register: a new result replaces one taken this cycle
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- checks ----------------
    `GTS_ASSERT_IMPL(a_ready_idle, clk, rst_n, tri_in.ready, state_reg == S_IDLE,
        "input taken outside idle")
    `GTS_ASSERT_NEXT(a_hold, clk, rst_n, res_out.valid && !res_out.ready,
        res_out.valid && $stable(res_out.data), "result dropped while stalled")
    `GTS_ASSERT_IMPL(a_last_face, clk, rst_n, res_out.valid && res_out.data.last,
        res_out.data.result_kind == gts_pkg::KIND_FACE, "last on a vertex result")
    `GTS_ASSERT_NEXT(a_done_idle, clk, rst_n,
        state_reg == S_FOUT && face_reg == 2'd3 && (!out_valid_reg || out_acc),
        state_reg == S_IDLE, "sequencer busy after final result")

endmodule

// ===== tb/sv/tb_geodesic_triangle_subdivide.sv =====
// ---------------------------------------------------------------------------
// tb_geodesic_triangle_subdivide
// Self-checking bench for the geodesic subdivider. Triangles go in on a
// valid/ready channel with random gaps, and the results are checked field by
// field against an in-bench projection and index allocator. The run covers
// several radius and base-count settings, counter wrap, and one long
// receiver hold-off.
// ---------------------------------------------------------------------------
module tb_geodesic_triangle_subdivide;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  HOLD_CYCLES = 4000;
    localparam int  IW          = gts_pkg::IDX_W;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_BASE   = 3'd4;

    typedef struct {
        gts_pkg::tri_t t;
        bit            pos_zero;   // every new vertex is known to be the origin
    } tri_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gts_tri_if tri_ch();
    gts_res_if res_ch();

    geodesic_triangle_subdivide dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the block's registers and counter
    logic [30:0]     sphere_radius;
    logic [IW-1:0]   next_index;
    logic            wrap_seen;

    gts_pkg::res_t expected_results[$];
    int   fail_count;
    int   cycle_count;
    bit   quiet;
    bit   hold_req;
    int   hold_left;
    int   stall_left;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // append one expected transaction
    function automatic void queue_expected(gts_pkg::res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // midpoint of one edge pushed out to the sphere
    function automatic void project_edge(input logic [31:0] a[3], input logic [31:0] b[3],
                                         output logic [31:0] p[3]);
        longint      s;
        logic [63:0] mag[3];
        bit          neg[3];
        logic [63:0] mx;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sq = 0;
        for (int j = 0; j < 3; j++)
        begin
            s = longint'($signed(a[j])) + longint'($signed(b[j]));
            neg[j] = s < 0;
            mag[j] = neg[j] ? -s : s;
            if (mag[j] > mx)
                mx = mag[j];
        end
        if (mx == 0)
        begin
            p = '{32'd0, 32'd0, 32'd0};
            return;
        end
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int j = 0; j < 3; j++)
                mag[j] = mag[j] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int j = 0; j < 3; j++)
                mag[j] = mag[j] << 1;
        end
        for (int j = 0; j < 3; j++)
            sq += mag[j] * mag[j];
        len = isqrt64(sq);
        for (int j = 0; j < 3; j++)
        begin
            q = (64'(sphere_radius) * mag[j] + (len >> 1)) / len;
            p[j] = neg[j] ? 32'(-q) : 32'(q);
        end
    endfunction

    // seven results of one subdivided triangle
    function automatic void predict_subdivision(gts_pkg::tri_t t);
        logic [31:0]   c[3][3];
        logic [31:0]   p[3];
        logic [IW-1:0] k[3];
        logic [IW-1:0] fa[4];
        logic [IW-1:0] fb[4];
        logic [IW-1:0] fc[4];
        gts_pkg::res_t r;
        c[0] = '{t.corner0_x, t.corner0_y, t.corner0_z};
        c[1] = '{t.corner1_x, t.corner1_y, t.corner1_z};
        c[2] = '{t.corner2_x, t.corner2_y, t.corner2_z};
        for (int e = 0; e < 3; e++)
        begin
            k[e] = next_index;
            next_index = next_index + 1'b1;
            if (next_index == 0)
                wrap_seen = 1'b1;
        end
        for (int e = 0; e < 3; e++)
        begin
            project_edge(c[e == 2 ? 1 : 0], c[e == 0 ? 1 : 2], p);
            r = '0;
            r.result_kind    = gts_pkg::KIND_VERTEX;
            r.vertex_index   = k[e];
            r.pos_x          = p[0];
            r.pos_y          = p[1];
            r.pos_z          = p[2];
            r.index_overflow = wrap_seen;
            queue_expected(r);
        end
        fa = '{t.corner0_index, t.corner1_index, t.corner2_index, k[0]};
        fb = '{k[0], k[0], k[1], k[1]};
        fc = '{k[1], k[2], k[2], k[2]};
        for (int f = 0; f < 4; f++)
        begin
            r = '0;
            r.result_kind    = gts_pkg::KIND_FACE;
            r.face_a         = fa[f];
            r.face_b         = fb[f];
            r.face_c         = fc[f];
            r.index_overflow = wrap_seen;
            r.last           = (f == 3);
            queue_expected(r);
        end
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        gts_pkg::res_t e;
        gts_pkg::res_t a;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            a = res_ch.data;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("result_kind", e.result_kind, a.result_kind);
                check_field("vertex_index", e.vertex_index, a.vertex_index);
                check_field("pos_x", e.pos_x, a.pos_x);
                check_field("pos_y", e.pos_y, a.pos_y);
                check_field("pos_z", e.pos_z, a.pos_z);
                check_field("face_a", e.face_a, a.face_a);
                check_field("face_b", e.face_b, a.face_b);
                check_field("face_c", e.face_c, a.face_c);
                check_field("index_overflow", e.index_overflow, a.index_overflow);
                check_field("last", e.last, a.last);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIUS)
            sphere_radius = value[30:0];
        else
        begin
            next_index = value[IW-1:0];
            wrap_seen  = 1'b0;
        end
    endtask

    // offer one triangle, with an optional gap first
    task automatic send_triangle(gts_pkg::tri_t t);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            tri_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data  <= t;
        @(posedge clk);
        while (!tri_ch.ready)
            @(posedge clk);
        predict_subdivision(t);
    endtask

    task automatic drain();
        tri_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                  : 32'h80000000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic gts_pkg::tri_t rand_triangle();
        gts_pkg::tri_t t;
        int            mode;
        mode = $urandom_range(0, 9);
        mode = mode < 5 ? 0 : (mode < 9 ? 1 : 2);
        t.corner0_x = rand_coord(mode);
        t.corner0_y = rand_coord(mode);
        t.corner0_z = rand_coord(mode);
        t.corner1_x = rand_coord(mode);
        t.corner1_y = rand_coord(mode);
        t.corner1_z = rand_coord(mode);
        t.corner2_x = rand_coord(mode);
        t.corner2_y = rand_coord(mode);
        t.corner2_z = rand_coord(mode);
        // now and then an edge through the origin
        if ($urandom_range(0, 9) == 0)
        begin
            t.corner1_x = -t.corner0_x;
            t.corner1_y = -t.corner0_y;
            t.corner1_z = -t.corner0_z;
        end
        t.corner0_index = IW'($urandom());
        t.corner1_index = IW'($urandom());
        t.corner2_index = IW'($urandom());
        return t;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_triangle(rand_triangle());
    endtask

    tri_row_t directed_rows[] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 24'd0, 24'd0, 24'd0}, 1'b1},
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1},
        '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            24'd1, 24'd2, 24'd3}, 1'b0},
        '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            24'hFFFFFF, 24'd0, 24'h800000}, 1'b0},
        '{'{32'sh7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'sh7FFFFFFF, 0,
            32'sh10000, 0, 32'h80000000, 24'd10, 24'd20, 24'd30}, 1'b0},
        '{'{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000,
            24'd0, 24'd1, 24'd2}, 1'b0},
        '{'{32'sh10000, 32'sh20000, -32'sh30000, -32'sh10000, -32'sh20000, 32'sh30000,
            32'sh5000, 32'sh7000, 32'sh9000, 24'h555555, 24'hAAAAAA, 24'h123456}, 1'b0},
        '{'{1, 0, 0, 0, 0, 1, 0, 1, 0, 24'd7, 24'd8, 24'd9}, 1'b0},
        '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1, 24'd3, 24'd2, 24'd1}, 1'b0},
        '{'{32'sh40000000, 1, -1, 32'sh40000000, -1, 1, -32'sh40000000, 0, 0,
            24'hFFFFFE, 24'h000001, 24'h7FFFFF}, 1'b0}
    };

    // stimulus
    initial
    begin
        gts_pkg::res_t r;
        int            n;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tri_ch.valid = 1'b0;
        tri_ch.data  = '0;
        res_ch.ready = 1'b0;
        sphere_radius = 31'd65536;
        next_index    = '0;
        wrap_seen     = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        stall_left    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: radius 1.0, indices from 0
        foreach (directed_rows[i])
        begin
            send_triangle(directed_rows[i].t);
            // the seven entries just queued for this row
            n = expected_results.size() - 7;
            if (directed_rows[i].pos_zero)
                for (int v = 0; v < 3; v++)
                begin
                    r = expected_results[n + v];
                    check_field("directed pos_x", 0, r.pos_x);
                    check_field("directed pos_y", 0, r.pos_y);
                    check_field("directed pos_z", 0, r.pos_z);
                end
        end
        drain();

        // widest radius, counter about to wrap; long hold-off here
        reg_write(ADDR_RADIUS, 32'hFFFFFFFF);
        reg_write(ADDR_BASE, 32'hFFFFFFFE);
        random_phase(10);
        hold_req = 1'b1;
        random_phase(50);
        drain();

        // smallest nonzero radius
        reg_write(ADDR_RADIUS, 32'd1);
        reg_write(ADDR_BASE, 32'd0);
        random_phase(60);
        drain();

        // zero radius
        reg_write(ADDR_RADIUS, 32'd0);
        reg_write(ADDR_BASE, 32'h00FFFFFF);
        random_phase(20);
        drain();

        // random settings
        reg_write(ADDR_RADIUS, $urandom());
        reg_write(ADDR_BASE, $urandom());
        random_phase(110);
        drain();

        // back to unit radius, no idling to the end
        reg_write(ADDR_RADIUS, 32'd65536);
        reg_write(ADDR_BASE, 32'h00FFFFF0);
        quiet = 1'b1;
        random_phase(90);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gts_pkg.sv
rtl/core/gts_if.sv
rtl/core/geodesic_triangle_subdivide.sv
tb/sv/tb_geodesic_triangle_subdivide.sv
